/* rtl/vpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpf_pkg
// Shared types, register map, beam timing and NTSC palette for the playfield
// pixel generator.
// ----------------------------------------------------------------------------
package vpf_pkg;

  localparam int unsigned LINE_CLOCKS_DEFAULT = 228;
  localparam int unsigned FRAME_LINES_DEFAULT = 262;

  localparam logic [7:0] HBLANK_END = 8'd68;
  localparam logic [7:0] HBLANK_STOP = 8'd228;
  localparam logic [8:0] VBLANK_END = 9'd40;
  localparam logic [8:0] VBLANK_STOP = 9'd232;
  localparam logic [5:0] HALF_SLOTS = 6'd20;
  localparam logic [5:0] LAST_SLOT = 6'd39;

  typedef enum logic [5:0] {
    ADDR_VSYNC  = 6'd0,
    ADDR_WSYNC  = 6'd2,
    ADDR_COLUP0 = 6'd6,
    ADDR_COLUP1 = 6'd7,
    ADDR_COLUPF = 6'd8,
    ADDR_COLUBK = 6'd9,
    ADDR_CTRLPF = 6'd10,
    ADDR_PF0    = 6'd13,
    ADDR_PF1    = 6'd14,
    ADDR_PF2    = 6'd15
  } reg_addr_t;

  typedef struct packed {
    logic [7:0] pf_low;
    logic [7:0] pf_mid;
    logic [7:0] pf_high;
    logic       reflect;
    logic       score;
    logic [7:0] col_p0;
    logic [7:0] col_p1;
    logic [7:0] col_pf;
    logic [7:0] col_bk;
  } pf_state_t;

  localparam logic [23:0] NTSC_ROM [128] = '{
    24'h000000, 24'h404040, 24'h6c6c6c, 24'h909090,
    24'hb0b0b0, 24'hc8c8c8, 24'hdcdcdc, 24'hf4f4f4,
    24'h444400, 24'h646410, 24'h848424, 24'ha0a034,
    24'hb8b840, 24'hd0d050, 24'he8e85c, 24'hfcfc68,
    24'h702800, 24'h844414, 24'h985c28, 24'hac783c,
    24'hbc8c4c, 24'hcca05c, 24'hdcb468, 24'hecc878,
    24'h841800, 24'h983418, 24'hac5030, 24'hc06848,
    24'hd0805c, 24'he09470, 24'heca880, 24'hfcbc94,
    24'h880000, 24'h9c2020, 24'hb03c3c, 24'hc05858,
    24'hd07070, 24'he08888, 24'heca0a0, 24'hfcb4b4,
    24'h78005c, 24'h8c2074, 24'ha03c88, 24'hb0589c,
    24'hc070b0, 24'hd084c0, 24'hdc9cd0, 24'hecb0e0,
    24'h480078, 24'h602090, 24'h783ca4, 24'h8c58b8,
    24'ha070cc, 24'hb484dc, 24'hc49cec, 24'hd4b0fc,
    24'h140084, 24'h302098, 24'h4c3cac, 24'h6858c0,
    24'h7c70d0, 24'h9488e0, 24'ha8a0ec, 24'hbcb4fc,
    24'h000088, 24'h1c209c, 24'h3840b0, 24'h505cc0,
    24'h6874d0, 24'h7c8ce0, 24'h90a4ec, 24'ha4b8fc,
    24'h00187c, 24'h1c3890, 24'h3854a8, 24'h5070bc,
    24'h6888cc, 24'h7c9cdc, 24'h90b4ec, 24'ha4c8fc,
    24'h002c5c, 24'h1c4c78, 24'h386890, 24'h5084ac,
    24'h689cc0, 24'h7cb4d4, 24'h90cce8, 24'ha4e0fc,
    24'h003c2c, 24'h1c5c48, 24'h387c64, 24'h509c80,
    24'h68b494, 24'h7cd0ac, 24'h90e4c0, 24'ha4fcd4,
    24'h003c00, 24'h205c20, 24'h407c40, 24'h5c9c5c,
    24'h74b474, 24'h8cd08c, 24'ha4e4a4, 24'hb8fcb8,
    24'h143800, 24'h345c1c, 24'h507c38, 24'h6c9850,
    24'h84b468, 24'h9ccc7c, 24'hb4e490, 24'hc8fca4,
    24'h2c3000, 24'h4c501c, 24'h687034, 24'h848c4c,
    24'h9ca864, 24'hb4c078, 24'hccd488, 24'he0ec9c,
    24'h442800, 24'h644818, 24'h846830, 24'ha08444,
    24'hb89c58, 24'hd0b46c, 24'he8cc7c, 24'hfce08c
  };

endpackage
`default_nettype wire

/* rtl/vpf_color.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpf_color
// Playfield bit selection, color register choice and palette lookup for one
// visible column.
// ----------------------------------------------------------------------------
module vpf_color
  import vpf_pkg::*;
(
  input  wire pf_state_t   pf,
  input  wire logic [7:0]  pcol,
  output logic [23:0]      rgb
);

  logic [5:0] slot;
  logic       left_half;
  logic [5:0] slot_fold;
  logic [4:0] idx;
  logic [4:0] mid_off;
  logic [4:0] high_off;
  logic       pf_on;
  logic [7:0] color;

  always_comb begin
    slot      = pcol[7:2];
    left_half = slot < HALF_SLOTS;
    if (pf.reflect && !left_half) begin
      slot_fold = LAST_SLOT - slot;
    end else if (!left_half) begin
      slot_fold = slot - HALF_SLOTS;
    end else begin
      slot_fold = slot;
    end
    idx      = slot_fold[4:0];
    mid_off  = 5'd11 - idx;
    high_off = idx - 5'd12;
    priority if (idx < 5'd4) begin
      pf_on = pf.pf_low[{1'b1, idx[1:0]}];
    end else if (idx < 5'd12) begin
      pf_on = pf.pf_mid[mid_off[2:0]];
    end else begin
      pf_on = pf.pf_high[high_off[2:0]];
    end
    if (!pf_on) begin
      color = pf.col_bk;
    end else if (pf.score) begin
      color = left_half ? pf.col_p0 : pf.col_p1;
    end else begin
      color = pf.col_pf;
    end
    rgb = NTSC_ROM[color[7:1]];
  end

endmodule
`default_nettype wire

/* rtl/video_playfield_pixel_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_playfield_pixel_generator
// Beam counter, register file and playfield pixel path with NTSC palette.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    req_type, reg_addr, reg_data
//   out      output     out_valid/out_ready  pixel_valid, pixel_col, pixel_row,
//                                            pixel_rgb, cpu_ready
//
// One transaction per cycle sustained unless the output stalls. Path: input
// register, then beam update, playfield pick and palette lookup into the
// result register. Each transaction yields exactly one result. A stalled
// output holds the result register; the input register then holds one more
// transaction before in_ready drops. Reset clears beam, registers and hold.
// ----------------------------------------------------------------------------
module video_playfield_pixel_generator
  import vpf_pkg::*;
#(
  parameter int unsigned LINE_CLOCKS = LINE_CLOCKS_DEFAULT,
  parameter int unsigned FRAME_LINES = FRAME_LINES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [5:0]  reg_addr,
  input  wire logic [7:0]  reg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pixel_valid,
  output logic [7:0]       pixel_col,
  output logic [7:0]       pixel_row,
  output logic [23:0]      pixel_rgb,
  output logic             cpu_ready
);

  localparam logic [8:0] LINE_END  = 9'(LINE_CLOCKS);
  localparam logic [9:0] FRAME_END = 10'(FRAME_LINES);

  logic       s1_valid;
  logic       s1_type;
  logic [5:0] s1_addr;
  logic [7:0] s1_data;

  logic [7:0] beam_col;
  logic [8:0] beam_row;
  logic       cpu_halted;
  pf_state_t  pf;

  logic [7:0] beam_col_next;
  logic [8:0] beam_row_next;
  logic       cpu_halted_next;
  pf_state_t  pf_next;

  logic       advance;
  logic       accept;
  logic [7:0] col_inc;
  logic [8:0] row_inc;
  logic       line_wrap;
  logic       frame_wrap;
  logic       visible;
  logic [7:0] pcol;
  logic [8:0] prow_full;
  logic [23:0] rgb;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type <= req_type;
      s1_addr <= reg_addr;
      s1_data <= reg_data;
    end
  end

  always_comb begin
    col_inc    = beam_col + 8'd1;
    row_inc    = beam_row + 9'd1;
    line_wrap  = {1'b0, col_inc} >= LINE_END;
    frame_wrap = {1'b0, row_inc} >= FRAME_END;

    beam_col_next   = beam_col;
    beam_row_next   = beam_row;
    cpu_halted_next = cpu_halted;
    pf_next         = pf;

    if (s1_type) begin
      unique case (s1_addr)
        ADDR_VSYNC: begin
          if (s1_data != 8'd0) begin
            beam_col_next = 8'd0;
            beam_row_next = 9'd0;
          end
        end
        ADDR_WSYNC:  cpu_halted_next = 1'b1;
        ADDR_COLUP0: pf_next.col_p0  = s1_data;
        ADDR_COLUP1: pf_next.col_p1  = s1_data;
        ADDR_COLUPF: pf_next.col_pf  = s1_data;
        ADDR_COLUBK: pf_next.col_bk  = s1_data;
        ADDR_CTRLPF: begin
          pf_next.reflect = s1_data[0];
          pf_next.score   = s1_data[1];
        end
        ADDR_PF0: pf_next.pf_low  = s1_data;
        ADDR_PF1: pf_next.pf_mid  = s1_data;
        ADDR_PF2: pf_next.pf_high = s1_data;
        default: ;
      endcase
    end else begin
      if (line_wrap) begin
        beam_col_next   = 8'd0;
        beam_row_next   = frame_wrap ? 9'd0 : row_inc;
        cpu_halted_next = 1'b0;
      end else begin
        beam_col_next = col_inc;
      end
    end

    visible = !s1_type &&
              beam_col_next >= HBLANK_END && beam_col_next < HBLANK_STOP &&
              beam_row_next >= VBLANK_END && beam_row_next < VBLANK_STOP;
    pcol      = beam_col_next - HBLANK_END;
    prow_full = beam_row_next - VBLANK_END;
  end

  vpf_color u_color (
    .pf   (pf),
    .pcol (pcol),
    .rgb  (rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_col   <= 8'd0;
      beam_row   <= 9'd0;
      cpu_halted <= 1'b0;
      pf         <= '0;
    end else if (advance) begin
      beam_col   <= beam_col_next;
      beam_row   <= beam_row_next;
      cpu_halted <= cpu_halted_next;
      pf         <= pf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_valid <= visible;
      pixel_col   <= visible ? pcol : 8'd0;
      pixel_row   <= visible ? prow_full[7:0] : 8'd0;
      pixel_rgb   <= visible ? rgb : 24'd0;
      cpu_ready   <= !cpu_halted_next;
    end
  end

  ap_beam_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, beam_col} < LINE_END) && ({1'b0, beam_row} < FRAME_END))
    else $error("beam position outside the frame");

  ap_pixel_in_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_valid |-> (pixel_col < 8'd160) && (pixel_row < 8'd192))
    else $error("pixel outside the visible window");

  ap_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a held result");

  ap_wsync_holds: assert property (@(posedge clk) disable iff (rst)
    advance && s1_type && (s1_addr == ADDR_WSYNC) |=> !cpu_ready && cpu_halted)
    else $error("wsync write did not hold the cpu");

endmodule
`default_nettype wire
